FILE: src/assert_macros.svh
// assertion macros shared by the divider rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ICD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("divider assertion failed");

// condition must never be seen out of reset
`define ICD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("divider forbidden condition seen");

`else

`define ICD_ASSERT(lbl, prop)
`define ICD_NEVER(lbl, cond)

`endif

`endif

FILE: src/icd_pkg.sv
// shared constants and types for the integer divider
`timescale 1ns / 1ps

package icd_pkg;

  localparam int DATA_WIDTH = 32;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // classified request handed from the front end to the divide pipeline
  typedef struct packed {
    word_t num;     // dividend magnitude
    word_t den;     // divisor magnitude
    logic  neg_q;   // negate quotient at the end
    logic  neg_r;   // negate remainder at the end
    logic  dbz;     // divisor was zero
  } div_item_t;

endpackage

FILE: src/int32_divider_signed_unsigned.sv
// top level of the 32-bit signed and unsigned integer divider
`timescale 1ns / 1ps

// 32-bit integer divider with a valid/ready request channel and a valid/ready
// result channel. in_op selects unsigned (0) or signed two's complement (1)
// division; every request yields exactly one result, in order. the quotient
// truncates toward zero and the signed remainder takes the dividend's sign.
// the most negative value divided by minus one wraps to the most negative
// value with a zero remainder. a zero divisor raises out_div_by_zero and
// returns zero for both quotient and remainder. throughput is one request per
// cycle while the result side keeps up. an accepted request is written into
// the two-entry queue, then passes through the 32 restoring stages, one
// quotient bit each, and then the sign fixup register drives the result.
// the front end takes magnitudes of the operands and flags divide by zero,
// the queue lets it keep accepting until both entries are full while the
// divide pipeline is stalled by the result side.
module int32_divider_signed_unsigned
  import icd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  // request channel
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_op,
  input  word_t in_dividend,
  input  word_t in_divisor,
  // result channel
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_quotient,
  output word_t out_remainder,
  output logic  out_div_by_zero
);

  div_item_t fe_item;    // classified request from the front end
  div_item_t q_item;     // head of the queue
  logic      q_valid;
  logic      be_ready;

  // classify: magnitudes, final sign flags, zero divisor
  icd_front u_front (
    .op       (in_op),
    .dividend (in_dividend),
    .divisor  (in_divisor),
    .item     (fe_item)
  );

  // decouples request accept from pipeline stalls
  icd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (fe_item),
    .pop_valid  (q_valid),
    .pop_ready  (be_ready),
    .pop_item   (q_item)
  );

  // restoring divide pipeline and output register
  icd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (q_valid),
    .in_ready        (be_ready),
    .in_item         (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_quotient    (out_quotient),
    .out_remainder   (out_remainder),
    .out_div_by_zero (out_div_by_zero)
  );

endmodule

FILE: src/icd_front.sv
// front end: turns a raw request into magnitudes and sign flags
`timescale 1ns / 1ps

module icd_front
  import icd_pkg::*;
(
  input  logic      op,
  input  word_t     dividend,
  input  word_t     divisor,
  output div_item_t item
);

  logic n_neg;
  logic d_neg;

  assign n_neg = op & dividend[DATA_WIDTH-1];
  assign d_neg = op & divisor[DATA_WIDTH-1];

  always_comb begin
    item.num   = n_neg ? (~dividend + word_t'(1)) : dividend;
    item.den   = d_neg ? (~divisor + word_t'(1)) : divisor;
    item.neg_q = n_neg ^ d_neg;
    item.neg_r = n_neg;
    item.dbz   = (divisor == '0);
  end

endmodule

FILE: src/icd_queue.sv
// two-entry queue between the front end and the divide pipeline
`timescale 1ns / 1ps

`include "assert_macros.svh"

module icd_queue
  import icd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  div_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output div_item_t pop_item
);

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  div_item_t         entry_r [QDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != CntW'(QDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // occupancy must agree with the pointer distance
  `ICD_ASSERT(a_q_ptr_match, (count_r == '0 || count_r == CntW'(QDepth)) |-> (wr_ptr_r == rd_ptr_r))
  `ICD_NEVER(a_q_overfill, count_r > CntW'(QDepth))

endmodule

FILE: src/icd_back.sv
// back end: restoring divide pipeline, one quotient bit per stage, sign fixup
`timescale 1ns / 1ps

`include "assert_macros.svh"

module icd_back
  import icd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output word_t     out_quotient,
  output word_t     out_remainder,
  output logic      out_div_by_zero
);

  // nq holds the dividend bits still to come, quotient bits fill in at the bottom
  typedef struct packed {
    word_t nq;
    word_t rem;
    word_t den;
    logic  neg_q;
    logic  neg_r;
    logic  dbz;
  } stg_t;

  function automatic stg_t div_step(input stg_t s);
    stg_t                  r;
    logic [DATA_WIDTH:0]   part;
    logic [DATA_WIDTH+1:0] diff;
    r    = s;
    part = {s.rem, s.nq[DATA_WIDTH-1]};
    diff = {1'b0, part} - {2'b00, s.den};
    if (!diff[DATA_WIDTH+1]) begin
      r.rem = diff[DATA_WIDTH-1:0];
      r.nq  = {s.nq[DATA_WIDTH-2:0], 1'b1};
    end else begin
      r.rem = part[DATA_WIDTH-1:0];
      r.nq  = {s.nq[DATA_WIDTH-2:0], 1'b0};
    end
    return r;
  endfunction

  stg_t  stg_in [DATA_WIDTH];
  stg_t  stg_r  [DATA_WIDTH];
  logic  vld_r  [DATA_WIDTH];
  logic  adv;
  stg_t  last;

  logic  out_valid_r;
  word_t out_quotient_r;
  word_t out_remainder_r;
  logic  out_dbz_r;

  // whole pipeline moves together whenever the output slot can take a result
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    stg_in[0]       = '0;
    stg_in[0].nq    = in_item.num;
    stg_in[0].den   = in_item.den;
    stg_in[0].neg_q = in_item.neg_q;
    stg_in[0].neg_r = in_item.neg_r;
    stg_in[0].dbz   = in_item.dbz;
  end

  for (genvar k = 1; k < DATA_WIDTH; k++) begin : g_link
    assign stg_in[k] = stg_r[k-1];
  end

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= div_step(stg_in[k]);
      end
    end

    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (adv) begin
          vld_r[k] <= in_valid;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (adv) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign last = stg_r[DATA_WIDTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[DATA_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[DATA_WIDTH-1]) begin
      out_dbz_r <= last.dbz;
      if (last.dbz) begin
        out_quotient_r  <= '0;
        out_remainder_r <= '0;
      end else begin
        out_quotient_r  <= last.neg_q ? (~last.nq + word_t'(1)) : last.nq;
        out_remainder_r <= last.neg_r ? (~last.rem + word_t'(1)) : last.rem;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_quotient    = out_quotient_r;
  assign out_remainder   = out_remainder_r;
  assign out_div_by_zero = out_dbz_r;

  // restoring step keeps the partial remainder below the divisor
  `ICD_ASSERT(a_rem_below_den, (vld_r[DATA_WIDTH-1] && !last.dbz) |-> (last.rem < last.den))
  // a zero divisor always yields zero results
  `ICD_ASSERT(a_dbz_zero, (out_valid_r && out_dbz_r) |-> (out_quotient_r == '0 && out_remainder_r == '0))
  // a finished item reaches the output slot on the next advance
  `ICD_ASSERT(a_drain, (adv && vld_r[DATA_WIDTH-1]) |=> out_valid_r)

endmodule
